/* rtl/delayed_task_timer_table_macros.svh */
// ----------------------------------------------------------------------------
// Delayed task timer table assertion macros
// Shared concurrent assertion forms for the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef DELAYED_TASK_TIMER_TABLE_MACROS_SVH
`define DELAYED_TASK_TIMER_TABLE_MACROS_SVH

// Same-cycle implication under reset.
`define DTT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// Next-cycle implication under reset.
`define DTT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

/* rtl/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// Delayed task timer table package
// Widths, codes, state types and request/response types shared by the table.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int MAX_DELAYED = 16;
  localparam int SLOT_W      = $clog2(MAX_DELAYED);
  localparam int TASK_W      = 8;
  localparam int MS_W        = 24;
  localparam int RATE_W      = 17;
  localparam int TICKS_W     = 32;
  localparam int PROD_W      = MS_W + RATE_W;
  localparam int MS_PER_SEC  = 1000;
  localparam int REM_W       = $clog2(MS_PER_SEC);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // 1000 = 8 * 125: shift out the 8, then multiply by a rounded-up 1/125
  localparam int DIV8_SH   = 3;
  localparam int RCP_MS_W  = 22;
  localparam int RCP_MS_SH = 28;
  localparam logic [RCP_MS_W-1:0] RCP_MS = RCP_MS_W'(2147484);
  localparam int SPLIT_W   = MS_W - DIV8_SH + RCP_MS_W;
  localparam int QM_W      = SPLIT_W - RCP_MS_SH;
  localparam int Z_W       = REM_W + RATE_W;
  localparam int RCP_Z_W   = 25;
  localparam int RCP_Z_SH  = 31;
  localparam logic [RCP_Z_W-1:0] RCP_Z = RCP_Z_W'(17179870);
  localparam int QUO_W     = Z_W - DIV8_SH + RCP_Z_W;
  localparam int QZ_W      = QUO_W - RCP_Z_SH;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

  typedef enum logic [0:0] {
    OP_DELAY = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCEPTED  = 2'd0,
    KIND_FULL      = 2'd1,
    KIND_RELEASED  = 2'd2,
    KIND_IDLE_TICK = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_DELAY    = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_NOP_TICK = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_SPLIT,
    FR_REM,
    FR_MUL,
    FR_QUO,
    FR_SUM,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_RELEASE
  } bk_state_e;

  typedef struct packed {
    op_e               op;
    logic [TASK_W-1:0] task_id;
    logic [MS_W-1:0]   delay_ms;
    logic              running;
  } in_req_t;

  typedef struct packed {
    kind_e             kind;
    logic [TASK_W-1:0] released_task;
    logic              last;
  } out_rsp_t;

  typedef struct packed {
    cmd_e               code;
    logic [TASK_W-1:0]  task_id;
    logic [TICKS_W-1:0] ticks;
  } cmd_t;

endpackage

/* rtl/delayed_task_timer_table.sv */
// Delay request: the front end steps through split by 1000, remainder, two products,
//   reciprocal quotient, sum and push, then the command is queued for the table engine.
// Tick: a releasing tick first updates the table, then emits one released id per cycle
//   while the output is not stalled (up to 16).
// The front end takes no new request until its command is pushed; output stalls back up.
// Reset: all slots free, tick rate 1000 Hz, queue and output register empty.
// ----------------------------------------------------------------------------
// Delayed task timer table
// Delay list with per-tick countdown: front end, command queue, table engine.
// ----------------------------------------------------------------------------
`include "delayed_task_timer_table_macros.svh"

module delayed_task_timer_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [dtt_pkg::RATE_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  dtt_pkg::in_req_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output dtt_pkg::out_rsp_t          out_rsp_o
);

  logic          fr_valid, fr_ready;
  dtt_pkg::cmd_t fr_cmd;
  logic          bk_valid, bk_ready;
  dtt_pkg::cmd_t bk_cmd;
  logic          in_fire, out_more, rel_out;

  dtt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  dtt_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cmd)
  );

  dtt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_more = out_valid_o && out_ready_i && !out_rsp_o.last;
  assign rel_out  = out_valid_o && (out_rsp_o.kind == dtt_pkg::KIND_RELEASED);

  `DTT_ASSERT_NXT(a_front_busy_after_request, clk_i, rst_ni, in_fire, !in_ready_o)
  `DTT_ASSERT_NXT(a_release_burst_unbroken, clk_i, rst_ni, out_more, rel_out)
  `DTT_ASSERT_IMP(a_queue_push_only_from_front, clk_i, rst_ni, fr_valid && fr_ready, !in_ready_o)

endmodule

/* rtl/dtt_front.sv */
// ----------------------------------------------------------------------------
// Timer table front end
// Accepts requests, converts delays to ticks by reciprocal division by 1000.
// ----------------------------------------------------------------------------
module dtt_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dtt_pkg::RATE_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dtt_pkg::in_req_t               in_req_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output dtt_pkg::cmd_t                  cmd_o
);

  dtt_pkg::fr_state_e                 state_q, state_d;
  logic [dtt_pkg::RATE_W-1:0]         rate_q;
  logic [dtt_pkg::TASK_W-1:0]         task_q, task_d;
  logic [dtt_pkg::MS_W-1:0]           ms_q, ms_d;
  logic [dtt_pkg::QM_W-1:0]           qm_q, qm_d;
  logic [dtt_pkg::REM_W-1:0]          rm_q, rm_d;
  logic [dtt_pkg::Z_W-1:0]            z_q, z_d;
  logic [dtt_pkg::TICKS_W-1:0]        hi_q, hi_d;
  logic [dtt_pkg::QZ_W-1:0]           qz_q, qz_d;
  logic [dtt_pkg::SPLIT_W-1:0]        split_prod;
  logic [dtt_pkg::MS_W-1:0]           rm_full;
  logic [dtt_pkg::QUO_W-1:0]          quo_prod;
  dtt_pkg::cmd_t                      cmd_q, cmd_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == dtt_pkg::FR_IDLE);
  assign cmd_valid_o = (state_q == dtt_pkg::FR_PUSH);
  assign cmd_o       = cmd_q;

  assign split_prod = dtt_pkg::SPLIT_W'(ms_q[dtt_pkg::MS_W-1:dtt_pkg::DIV8_SH]) *
                      dtt_pkg::SPLIT_W'(dtt_pkg::RCP_MS);
  assign rm_full    = ms_q - dtt_pkg::MS_W'(qm_q) * dtt_pkg::MS_W'(dtt_pkg::MS_PER_SEC);
  assign quo_prod   = dtt_pkg::QUO_W'(z_q[dtt_pkg::Z_W-1:dtt_pkg::DIV8_SH]) *
                      dtt_pkg::QUO_W'(dtt_pkg::RCP_Z);

  always_comb begin
    state_d = state_q;
    task_d  = task_q;
    ms_d    = ms_q;
    qm_d    = qm_q;
    rm_d    = rm_q;
    z_d     = z_q;
    hi_d    = hi_q;
    qz_d    = qz_q;
    cmd_d   = cmd_q;
    case (state_q)
      dtt_pkg::FR_IDLE: begin
        if (in_valid_i) begin
          task_d = in_req_i.task_id;
          ms_d   = in_req_i.delay_ms;
          if (in_req_i.op == dtt_pkg::OP_TICK) begin
            if (in_req_i.running) begin
              cmd_d.code = dtt_pkg::CMD_TICK;
            end else begin
              cmd_d.code = dtt_pkg::CMD_NOP_TICK;
            end
            cmd_d.task_id = '0;
            cmd_d.ticks   = '0;
            state_d       = dtt_pkg::FR_PUSH;
          end else begin
            state_d = dtt_pkg::FR_SPLIT;
          end
        end
      end
      dtt_pkg::FR_SPLIT: begin
        qm_d    = split_prod[dtt_pkg::SPLIT_W-1:dtt_pkg::RCP_MS_SH];
        state_d = dtt_pkg::FR_REM;
      end
      dtt_pkg::FR_REM: begin
        rm_d    = rm_full[dtt_pkg::REM_W-1:0];
        state_d = dtt_pkg::FR_MUL;
      end
      dtt_pkg::FR_MUL: begin
        z_d     = dtt_pkg::Z_W'(rm_q) * dtt_pkg::Z_W'(rate_q);
        hi_d    = dtt_pkg::TICKS_W'(qm_q) * dtt_pkg::TICKS_W'(rate_q);
        state_d = dtt_pkg::FR_QUO;
      end
      dtt_pkg::FR_QUO: begin
        qz_d    = quo_prod[dtt_pkg::QUO_W-1:dtt_pkg::RCP_Z_SH];
        state_d = dtt_pkg::FR_SUM;
      end
      dtt_pkg::FR_SUM: begin
        cmd_d.code    = dtt_pkg::CMD_DELAY;
        cmd_d.task_id = task_q;
        cmd_d.ticks   = hi_q + dtt_pkg::TICKS_W'(qz_q);
        state_d       = dtt_pkg::FR_PUSH;
      end
      dtt_pkg::FR_PUSH: begin
        if (cmd_ready_i) begin
          state_d = dtt_pkg::FR_IDLE;
        end
      end
      default: begin
        state_d = dtt_pkg::FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtt_pkg::FR_IDLE;
      rate_q  <= dtt_pkg::RATE_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        rate_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    ms_q   <= ms_d;
    qm_q   <= qm_d;
    rm_q   <= rm_d;
    z_q    <= z_d;
    hi_q   <= hi_d;
    qz_q   <= qz_d;
    cmd_q  <= cmd_d;
  end

endmodule

/* rtl/dtt_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Timer table command queue
// Two-entry queue that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module dtt_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  dtt_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output dtt_pkg::cmd_t pop_data_o
);

  dtt_pkg::cmd_t                   mem_q [dtt_pkg::FIFO_DEPTH];
  logic [dtt_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [dtt_pkg::FIFO_CNT_W-1:0]  count_q;
  logic                            push, pop;

  assign push_ready_o = (count_q != dtt_pkg::FIFO_CNT_W'(dtt_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/dtt_back.sv */
// ----------------------------------------------------------------------------
// Timer table engine
// Holds the slot table, runs delay and tick commands, emits responses.
// ----------------------------------------------------------------------------
module dtt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  dtt_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dtt_pkg::out_rsp_t out_rsp_o
);

  dtt_pkg::bk_state_e                  state_q, state_d;
  logic [dtt_pkg::MAX_DELAYED-1:0]     valid_q, valid_d;
  logic [dtt_pkg::MAX_DELAYED-1:0]     mask_q, mask_d;
  logic [dtt_pkg::TASK_W-1:0]          task_q  [dtt_pkg::MAX_DELAYED];
  logic [dtt_pkg::TICKS_W-1:0]         ticks_q [dtt_pkg::MAX_DELAYED];
  logic [dtt_pkg::MAX_DELAYED-1:0]     expire;
  logic [dtt_pkg::SLOT_W-1:0]          free_idx, rel_idx;
  logic                                free_found;
  logic [dtt_pkg::MAX_DELAYED-1:0]     rel_onehot;
  logic                                rel_last;
  logic                                out_valid_q, out_valid_d;
  dtt_pkg::out_rsp_t                   out_q, out_d;
  logic                                out_load_ok;
  logic                                wr_en, tick_en;

  assign out_load_ok = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == dtt_pkg::BK_IDLE) && out_load_ok;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    rel_idx    = '0;
    for (int i = dtt_pkg::MAX_DELAYED - 1; i >= 0; i--) begin
      expire[i] = valid_q[i] && (ticks_q[i] <= dtt_pkg::TICKS_W'(1));
      if (!valid_q[i]) begin
        free_idx   = dtt_pkg::SLOT_W'(i);
        free_found = 1'b1;
      end
      if (mask_q[i]) begin
        rel_idx = dtt_pkg::SLOT_W'(i);
      end
    end
    rel_onehot          = '0;
    rel_onehot[rel_idx] = 1'b1;
    rel_last            = ((mask_q & ~rel_onehot) == '0);
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    tick_en     = 1'b0;
    case (state_q)
      dtt_pkg::BK_IDLE: begin
        if (cmd_valid_i && out_load_ok) begin
          case (cmd_i.code)
            dtt_pkg::CMD_DELAY: begin
              wr_en               = free_found;
              out_valid_d         = 1'b1;
              out_d.kind          = free_found ? dtt_pkg::KIND_ACCEPTED : dtt_pkg::KIND_FULL;
              out_d.released_task = cmd_i.task_id;
              out_d.last          = 1'b1;
              if (free_found) begin
                valid_d[free_idx] = 1'b1;
              end
            end
            dtt_pkg::CMD_TICK: begin
              tick_en = 1'b1;
              valid_d = valid_q & ~expire;
              mask_d  = expire;
              if (expire != '0) begin
                state_d = dtt_pkg::BK_RELEASE;
              end else begin
                out_valid_d         = 1'b1;
                out_d.kind          = dtt_pkg::KIND_IDLE_TICK;
                out_d.released_task = '0;
                out_d.last          = 1'b1;
              end
            end
            dtt_pkg::CMD_NOP_TICK: begin
              out_valid_d         = 1'b1;
              out_d.kind          = dtt_pkg::KIND_IDLE_TICK;
              out_d.released_task = '0;
              out_d.last          = 1'b1;
            end
            default: begin
              out_valid_d = out_valid_q && !out_ready_i;
            end
          endcase
        end
      end
      dtt_pkg::BK_RELEASE: begin
        if (out_load_ok) begin
          out_valid_d         = 1'b1;
          out_d.kind          = dtt_pkg::KIND_RELEASED;
          out_d.released_task = task_q[rel_idx];
          out_d.last          = rel_last;
          mask_d              = mask_q & ~rel_onehot;
          if (rel_last) begin
            state_d = dtt_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_d = dtt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtt_pkg::BK_IDLE;
      valid_q     <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    for (int i = 0; i < dtt_pkg::MAX_DELAYED; i++) begin
      if (tick_en && valid_q[i] && !expire[i]) begin
        ticks_q[i] <= ticks_q[i] - dtt_pkg::TICKS_W'(1);
      end
    end
    if (wr_en) begin
      task_q[free_idx]  <= cmd_i.task_id;
      ticks_q[free_idx] <= cmd_i.ticks;
    end
  end

endmodule
